// ===== rtl/sht_pkg.sv =====
package sht_pkg;

  // number of seats served by the block
  localparam int NUM_SEATS = 2;

  // register map
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // field widths
  localparam int TEMP_W  = 8;
  localparam int LEVEL_W = 2;

  localparam logic [TEMP_W-1:0] SEAT_RESET_TEMP = 8'd22;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LOW_TARGET     = 3'd0,
    REG_MEDIUM_TARGET  = 3'd1,
    REG_HIGH_TARGET    = 3'd2,
    REG_GAP_FOR_HIGH   = 3'd3,
    REG_GAP_FOR_MEDIUM = 3'd4,
    REG_GAP_FOR_LOW    = 3'd5,
    REG_RESUME_GAP     = 3'd6,
    REG_OVERHEAT_LIMIT = 3'd7
  } reg_idx_t;

  localparam logic [TEMP_W-1:0] REG_RESET [NUM_REGS] = '{
    8'd25, 8'd30, 8'd35, 8'd10, 8'd5, 8'd2, 8'd3, 8'd40
  };

  typedef enum logic [LEVEL_W-1:0] {
    HEAT_OFF  = 2'd0,
    HEAT_LOW  = 2'd1,
    HEAT_MED  = 2'd2,
    HEAT_HIGH = 2'd3
  } heat_t;

  typedef enum logic {
    FUNC_BUTTON = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  // register contents handed to the seat core
  typedef struct packed {
    logic [TEMP_W-1:0] low_target;
    logic [TEMP_W-1:0] medium_target;
    logic [TEMP_W-1:0] high_target;
    logic [TEMP_W-1:0] gap_for_high;
    logic [TEMP_W-1:0] gap_for_medium;
    logic [TEMP_W-1:0] gap_for_low;
    logic [TEMP_W-1:0] resume_gap;
    logic [TEMP_W-1:0] overheat_limit;
  } cfg_t;

  typedef struct packed {
    logic              seat;
    logic              func;
    logic [TEMP_W-1:0] temperature;
    logic [TEMP_W-1:0] time_stamp;
  } in_item_t;

  typedef struct packed {
    logic               seat_out;
    logic [LEVEL_W-1:0] heat_level;
    logic [LEVEL_W-1:0] heat_intensity;
    logic               green_led;
    logic               blue_led;
    logic               red_led;
    logic [TEMP_W-1:0]  fault_reading;
    logic [TEMP_W-1:0]  fault_time;
  } out_item_t;

  // per-seat state
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] intensity;
    logic               paused;
    logic [TEMP_W-1:0]  temp;
    logic               fault;
    logic [TEMP_W-1:0]  fault_reading;
    logic [TEMP_W-1:0]  fault_time;
  } seat_state_t;

endpackage

// ===== rtl/sht_cfg_regs.sv =====
module sht_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sht_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sht_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sht_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output sht_pkg::cfg_t                 cfg
);
  import sht_pkg::*;

  logic [TEMP_W-1:0]    regs_r [NUM_REGS];
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= REG_RESET[i];
      end
    end else if (wr_en) begin
      regs_r[idx] <= pwdata[TEMP_W-1:0];
    end
  end

  // read back
  assign prdata = {{(CFG_DATA_W-TEMP_W){1'b0}}, regs_r[idx]};

  // register view for the core
  always_comb begin
    cfg.low_target     = regs_r[REG_LOW_TARGET];
    cfg.medium_target  = regs_r[REG_MEDIUM_TARGET];
    cfg.high_target    = regs_r[REG_HIGH_TARGET];
    cfg.gap_for_high   = regs_r[REG_GAP_FOR_HIGH];
    cfg.gap_for_medium = regs_r[REG_GAP_FOR_MEDIUM];
    cfg.gap_for_low    = regs_r[REG_GAP_FOR_LOW];
    cfg.resume_gap     = regs_r[REG_RESUME_GAP];
    cfg.overheat_limit = regs_r[REG_OVERHEAT_LIMIT];
  end

endmodule

// ===== rtl/sht_seat_core.sv =====
module sht_seat_core (
  input  logic                clk,
  input  logic                rst_n,
  input  sht_pkg::cfg_t       cfg,
  input  logic                upd,
  input  sht_pkg::in_item_t   item,
  output sht_pkg::out_item_t  result
);
  import sht_pkg::*;

  seat_state_t        state_r [NUM_SEATS];
  seat_state_t        cur;
  seat_state_t        state_nxt;
  logic               seat_ok;
  logic [LEVEL_W-1:0] lvl_n;
  logic [TEMP_W-1:0]  temp_n;
  logic [TEMP_W-1:0]  target;
  logic [TEMP_W-1:0]  gap;
  logic               below;
  logic               go;

  assign seat_ok = (32'(item.seat) < NUM_SEATS);
  assign cur     = state_r[item.seat];

  // event applied to the stored seat values
  assign lvl_n  = (item.func == FUNC_BUTTON) ? cur.level + 2'd1 : cur.level;
  assign temp_n = (item.func == FUNC_SAMPLE) ? item.temperature : cur.temp;

  // target for the selected level
  always_comb begin
    case (lvl_n)
      HEAT_LOW:  target = cfg.low_target;
      HEAT_MED:  target = cfg.medium_target;
      HEAT_HIGH: target = cfg.high_target;
      default:   target = cfg.low_target;
    endcase
  end

  assign below = temp_n < target;
  assign gap   = target - temp_n;

  // next seat state
  always_comb begin
    state_nxt = cur;
    go        = 1'b1;
    if (!cur.fault) begin
      state_nxt.level = lvl_n;
      state_nxt.temp  = temp_n;
      if (temp_n > cfg.overheat_limit) begin
        state_nxt.fault         = 1'b1;
        state_nxt.fault_reading = temp_n;
        state_nxt.fault_time    = item.time_stamp;
      end else if (lvl_n == HEAT_OFF) begin
        state_nxt.intensity = HEAT_OFF;
      end else begin
        // pause holds until the gap reaches the resume threshold
        if (cur.paused) begin
          if (below && gap >= cfg.resume_gap) begin
            state_nxt.paused = 1'b0;
          end else begin
            state_nxt.intensity = HEAT_OFF;
            go = 1'b0;
          end
        end
        if (go) begin
          if (below && gap >= cfg.gap_for_high) begin
            state_nxt.intensity = HEAT_HIGH;
          end else if (below && gap >= cfg.gap_for_medium) begin
            state_nxt.intensity = HEAT_MED;
          end else if (below && gap >= cfg.gap_for_low) begin
            state_nxt.intensity = HEAT_LOW;
          end else begin
            state_nxt.intensity = HEAT_OFF;
            state_nxt.paused    = 1'b1;
          end
        end
      end
    end
  end

  // seat state storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SEATS; i++) begin
        state_r[i].level         <= HEAT_OFF;
        state_r[i].intensity     <= HEAT_OFF;
        state_r[i].paused        <= 1'b0;
        state_r[i].temp          <= SEAT_RESET_TEMP;
        state_r[i].fault         <= 1'b0;
        state_r[i].fault_reading <= '0;
        state_r[i].fault_time    <= '0;
      end
    end else if (upd && seat_ok) begin
      state_r[item.seat] <= state_nxt;
    end
  end

  // result fields from the updated state
  always_comb begin
    result          = '0;
    result.seat_out = item.seat;
    if (seat_ok) begin
      result.heat_level     = state_nxt.level;
      result.heat_intensity = state_nxt.intensity;
      result.green_led      = !state_nxt.fault && state_nxt.intensity[0];
      result.blue_led       = !state_nxt.fault && state_nxt.intensity[1];
      result.red_led        = state_nxt.fault;
      result.fault_reading  = state_nxt.fault_reading;
      result.fault_time     = state_nxt.fault_time;
    end
  end

endmodule

// ===== rtl/seat_heater_thermostat.sv =====
// channel | dir | tdata (low bit up)                         | tuser
// in_     | in  | temperature, time_stamp                    | seat, func
// out_    | out | heat_level, heat_intensity, green, blue,   | seat_out
//         |     | red, fault_reading, fault_time, zero fill  |
// cfg_    | in  | apb write/read of the eight 8-bit settings | -
//
// one beat per cycle sustained while the result side is not stalled; a beat passes
// through the input register, then the result register; seat state updates as it moves
// from the input register into the result register
// reset is synchronous and clears settings, seat state and both valid flags
// a stalled result holds; the input register keeps accepting while the
// result register is free or is being taken in the same cycle
module seat_heater_thermostat (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // temperature, time_stamp
  input  logic [1:0]                      in_tuser,   // seat, func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // heat_level, heat_intensity,
                                                      // green_led, blue_led, red_led,
                                                      // fault_reading, fault_time
  output logic                            out_tuser,  // seat_out
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sht_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [sht_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [sht_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import sht_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t res;
  out_item_t out_item_r;
  logic      out_valid_r;
  logic      out_adv;
  logic      move;

  sht_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // handshake control
  assign out_adv   = !out_valid_r || out_tready;
  assign move      = in_valid_r && out_adv;
  assign in_tready = !in_valid_r || out_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.seat        <= in_tuser[0];
      in_item_r.func        <= in_tuser[1];
      in_item_r.temperature <= in_tdata[7:0];
      in_item_r.time_stamp  <= in_tdata[15:8];
    end
  end

  sht_seat_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .upd    (move),
    .item   (in_item_r),
    .result (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_item_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_item_r.seat_out;
  assign out_tdata  = {1'b0,
                       out_item_r.fault_time,
                       out_item_r.fault_reading,
                       out_item_r.red_led,
                       out_item_r.blue_led,
                       out_item_r.green_led,
                       out_item_r.heat_intensity,
                       out_item_r.heat_level};

endmodule

// ===== rtl/sht_checker.sv =====
module sht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

  // fault forces green and blue off
  a_fault_leds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |-> !out_tdata[4] && !out_tdata[5])
    else $error("indicator lit during fault");

  // without a fault the leds follow the intensity, and level off means off
  a_leds_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[6] |->
      out_tdata[4] == out_tdata[2] && out_tdata[5] == out_tdata[3] &&
      (out_tdata[1:0] != 2'd0 || out_tdata[3:2] == 2'd0))
    else $error("indicator or intensity inconsistent with level");

endmodule

bind seat_heater_thermostat sht_checker u_sht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== dv/tb_seat_heater_thermostat.sv =====
`timescale 1ns / 1ps

module tb_seat_heater_thermostat;
  import sht_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;   // temperature, time_stamp
  logic [1:0]            in_tuser = '0;   // seat, func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;       // heat_level, heat_intensity, green_led,
                                          // blue_led, red_led, fault_reading, fault_time
  logic                  out_tuser;       // seat_out
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  seat_heater_thermostat uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // shadow of the settings and of every seat
  logic [TEMP_W-1:0] set_val [NUM_REGS];
  logic [TEMP_W-1:0] plan [NUM_REGS];
  seat_state_t       seat_st [NUM_SEATS];

  in_item_t  event_q [$];
  out_item_t status_due [$];

  int issued = 0;
  int answered = 0;
  int bad_count = 0;
  int quiet_cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  // intensity and pause update of one seat after an event
  function automatic void refresh_heater(int s);
    logic [TEMP_W-1:0] tgt;
    logic [TEMP_W-1:0] gap;
    logic              below;
    if (seat_st[s].level == HEAT_OFF) begin
      seat_st[s].intensity = HEAT_OFF;
      return;
    end
    tgt = set_val[int'(seat_st[s].level) - 1];
    below = seat_st[s].temp < tgt;
    gap = below ? tgt - seat_st[s].temp : '0;
    // a paused heater needs the resume gap before it drives again
    if (seat_st[s].paused) begin
      if (below && gap >= set_val[REG_RESUME_GAP]) begin
        seat_st[s].paused = 1'b0;
      end else begin
        seat_st[s].intensity = HEAT_OFF;
        return;
      end
    end
    if (below && gap >= set_val[REG_GAP_FOR_HIGH]) begin
      seat_st[s].intensity = HEAT_HIGH;
    end else if (below && gap >= set_val[REG_GAP_FOR_MEDIUM]) begin
      seat_st[s].intensity = HEAT_MED;
    end else if (below && gap >= set_val[REG_GAP_FOR_LOW]) begin
      seat_st[s].intensity = HEAT_LOW;
    end else begin
      seat_st[s].intensity = HEAT_OFF;
      seat_st[s].paused = 1'b1;
    end
  endfunction

  // seat status that one press or sample leads to
  function automatic out_item_t heater_event(in_item_t ev);
    out_item_t r;
    int        s;
    s = ev.seat;
    r = '0;
    r.seat_out = ev.seat;
    if (s >= NUM_SEATS) return r;
    // a latched fault freezes the seat
    if (!seat_st[s].fault) begin
      if (ev.func == FUNC_BUTTON) seat_st[s].level = seat_st[s].level + 1'b1;
      else seat_st[s].temp = ev.temperature;
      if (seat_st[s].temp > set_val[REG_OVERHEAT_LIMIT]) begin
        seat_st[s].fault = 1'b1;
        seat_st[s].fault_reading = seat_st[s].temp;
        seat_st[s].fault_time = ev.time_stamp;
      end else begin
        refresh_heater(s);
      end
    end
    r.heat_level = seat_st[s].level;
    r.heat_intensity = seat_st[s].intensity;
    r.red_led = seat_st[s].fault;
    r.green_led = !seat_st[s].fault && seat_st[s].intensity[0];
    r.blue_led = !seat_st[s].fault && seat_st[s].intensity[1];
    r.fault_reading = seat_st[s].fault_reading;
    r.fault_time = seat_st[s].fault_time;
    return r;
  endfunction

  // random event, mostly with temperatures close to one of the targets
  function automatic in_item_t rand_event();
    in_item_t ev;
    int       t;
    int       lim;
    ev.seat = 1'($urandom_range(0, 1));
    ev.func = ($urandom_range(0, 9) < 3) ? FUNC_BUTTON : FUNC_SAMPLE;
    ev.time_stamp = 8'($urandom);
    lim = set_val[REG_OVERHEAT_LIMIT];
    if ($urandom_range(0, 4) == 0) begin
      t = $urandom_range(0, 255);
    end else begin
      t = set_val[$urandom_range(0, 2)];
      t = t - int'($urandom_range(0, 16)) + int'($urandom_range(0, 3));
      if (t < 0) t = 0;
      if (t > 255) t = 255;
    end
    // stay at or below the limit so the seats do not freeze early
    if (t > lim) t = $urandom_range(0, lim);
    ev.temperature = 8'(t);
    return ev;
  endfunction

  task automatic add_event(bit seat, func_t f, int temp, int stamp);
    in_item_t ev;
    ev.seat = seat;
    ev.func = f;
    ev.temperature = 8'(temp);
    ev.time_stamp = 8'(stamp);
    event_q.push_back(ev);
    issued++;
  endtask

  task automatic add_random(int n);
    repeat (n) begin
      event_q.push_back(rand_event());
      issued++;
    end
  endtask

  // wait until every queued event has its status back
  task automatic drain();
    while (answered != issued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_setting(reg_idx_t idx, logic [TEMP_W-1:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= CFG_DATA_W'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    set_val[idx] = v;
  endtask

  task automatic apply_plan();
    for (int i = 0; i < NUM_REGS; i++) write_setting(reg_idx_t'(i), plan[i]);
  endtask

  // driver: one event beat at a time, with random gaps between beats
  int gap_left = 0;
  in_item_t cur_ev;
  always @(posedge clk) begin
    logic busy;
    logic nxt_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        status_due.push_back(heater_event(cur_ev));
        busy = 1'b0;
      end
      if (!busy) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (event_q.size() > 0) begin
          if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap_left = $urandom_range(1, 15) - 1;
          end else begin
            cur_ev = event_q.pop_front();
            nxt_valid = 1'b1;
          end
        end
        in_tvalid <= nxt_valid;
        if (nxt_valid) begin
          in_tdata <= {cur_ev.time_stamp, cur_ev.temperature};
          in_tuser <= {cur_ev.func, cur_ev.seat};
        end
      end
    end
  end

  // monitor: compare each status beat with the oldest prediction
  int stall_left = 0;
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    logic      rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.seat_out = out_tuser;
        got.heat_level = out_tdata[1:0];
        got.heat_intensity = out_tdata[3:2];
        got.green_led = out_tdata[4];
        got.blue_led = out_tdata[5];
        got.red_led = out_tdata[6];
        got.fault_reading = out_tdata[14:7];
        got.fault_time = out_tdata[22:15];
        if (status_due.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) $display("status beat with nothing expected: %p", got);
        end else begin
          want = status_due.pop_front();
          answered++;
          if (got !== want) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("status mismatch: expected seat %0d lvl %0d int %0d g%0b b%0b r%0b rd %0d ts %0d",
                       want.seat_out, want.heat_level, want.heat_intensity, want.green_led,
                       want.blue_led, want.red_led, want.fault_reading, want.fault_time);
              $display("                 actual   seat %0d lvl %0d int %0d g%0b b%0b r%0b rd %0d ts %0d",
                       got.seat_out, got.heat_level, got.heat_intensity, got.green_led,
                       got.blue_led, got.red_led, got.fault_reading, got.fault_time);
            end
          end
        end
      end
      // random stall bursts on the result side
      rdy = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 15) - 1;
        rdy = 1'b0;
      end
      out_tready <= rdy;
    end
  end

  // cycles without any beat on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[seat_heater_thermostat] ERROR");
    $finish;
  end

  // stimulus
  initial begin
    set_val = REG_RESET;
    for (int i = 0; i < NUM_SEATS; i++) begin
      seat_st[i] = '0;
      seat_st[i].temp = SEAT_RESET_TEMP;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every intensity band, pause and resume, level wrap
    gap_pct = 10;
    stall_pct = 10;
    add_event(0, FUNC_SAMPLE, 0, 0);
    add_event(0, FUNC_BUTTON, 255, 255);
    add_event(0, FUNC_SAMPLE, 18, 1);
    add_event(0, FUNC_SAMPLE, 22, 2);
    add_event(0, FUNC_SAMPLE, 24, 3);
    add_event(0, FUNC_SAMPLE, 23, 4);
    add_event(0, FUNC_SAMPLE, 22, 5);
    add_event(0, FUNC_SAMPLE, 25, 6);
    add_event(0, FUNC_SAMPLE, 40, 7);
    add_event(0, FUNC_BUTTON, 0, 8);
    add_event(0, FUNC_BUTTON, 0, 9);
    add_event(0, FUNC_BUTTON, 0, 10);
    add_event(0, FUNC_BUTTON, 0, 11);
    add_event(0, FUNC_SAMPLE, 10, 12);
    add_event(1, FUNC_BUTTON, 0, 13);
    add_event(1, FUNC_BUTTON, 0, 14);
    add_event(1, FUNC_BUTTON, 0, 15);
    add_event(1, FUNC_SAMPLE, 0, 16);
    add_event(1, FUNC_SAMPLE, 33, 17);
    add_event(1, FUNC_SAMPLE, 35, 18);
    add_random(200);
    drain();

    // moderate random targets, no overheat possible
    plan = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255};
    for (int i = 0; i < 3; i++) plan[i] = 8'($urandom_range(20, 60));
    plan[REG_GAP_FOR_HIGH] = 8'($urandom_range(8, 14));
    plan[REG_GAP_FOR_MEDIUM] = 8'($urandom_range(4, 7));
    plan[REG_GAP_FOR_LOW] = 8'($urandom_range(1, 3));
    plan[REG_RESUME_GAP] = 8'($urandom_range(1, 6));
    apply_plan();
    gap_pct = 30;
    stall_pct = 0;
    add_random(205);
    drain();

    // top targets, zero gaps
    plan = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255};
    apply_plan();
    gap_pct = 0;
    stall_pct = 30;
    add_random(205);
    drain();

    // zero targets, widest gaps: never below target
    plan = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    apply_plan();
    gap_pct = 40;
    stall_pct = 40;
    add_random(205);
    drain();

    // anything goes, thresholds in no particular order
    for (int i = 0; i < NUM_REGS; i++) plan[i] = 8'($urandom);
    plan[REG_OVERHEAT_LIMIT] = 8'($urandom_range(100, 255));
    apply_plan();
    gap_pct = 20;
    stall_pct = 20;
    add_random(205);
    drain();

    // reversed gap thresholds, no idling from here on
    for (int i = 0; i < 3; i++) plan[i] = 8'($urandom_range(15, 80));
    plan[REG_GAP_FOR_HIGH] = 8'd1;
    plan[REG_GAP_FOR_MEDIUM] = 8'd3;
    plan[REG_GAP_FOR_LOW] = 8'd6;
    plan[REG_RESUME_GAP] = 8'($urandom_range(0, 10));
    plan[REG_OVERHEAT_LIMIT] = 8'd255;
    apply_plan();
    gap_pct = 0;
    stall_pct = 0;
    add_random(205);
    add_event(1, FUNC_SAMPLE, 200, 1);
    add_event(0, FUNC_SAMPLE, 0, 2);
    drain();

    // overheat: fault on a press, at the limit, just above it, then frozen seats
    write_setting(REG_OVERHEAT_LIMIT, 8'd0);
    add_event(1, FUNC_BUTTON, 0, 8'h5a);
    add_event(0, FUNC_SAMPLE, 0, 8'h11);
    add_event(0, FUNC_SAMPLE, 1, 8'hc3);
    add_event(0, FUNC_SAMPLE, 255, 8'h22);
    add_event(0, FUNC_BUTTON, 0, 8'h33);
    add_event(1, FUNC_SAMPLE, 0, 8'h44);
    add_random(30);
    drain();
    repeat (20) @(posedge clk);

    if (bad_count == 0 && status_due.size() == 0) begin
      $display("[seat_heater_thermostat] OK");
    end else begin
      $display("[seat_heater_thermostat] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sht_pkg.sv
rtl/sht_cfg_regs.sv
rtl/sht_seat_core.sv
rtl/seat_heater_thermostat.sv
rtl/sht_checker.sv
dv/tb_seat_heater_thermostat.sv
